// ===== rtl/core/pbve_pkg.sv =====
// Package for the posting block varbyte encoder.
// Item types, code constants and default block length; no dependencies.
package pbve_pkg;

    localparam int unsigned BLOCK_LEN_DEF = 128;
    localparam int unsigned VB_MAX_BYTES  = 5;

    localparam logic [47:0] HEADER_BYTES = 48'd12;
    localparam logic [9:0]  SUM_MAX      = 10'd1023;
    localparam logic        VB_CONT      = 1'b1;

    typedef struct packed {
        logic        flush;
        logic [31:0] word_id;
        logic [31:0] doc_id;
        logic [31:0] freq;
    } t_in_item;

    typedef struct packed {
        logic        posting_valid;
        logic [39:0] gap_code;
        logic [2:0]  gap_len;
        logic [39:0] freq_code;
        logic [2:0]  freq_len;
        logic        block_closed;
        logic [31:0] closed_last_doc;
        logic [9:0]  closed_gap_bytes;
        logic [9:0]  closed_freq_bytes;
        logic        word_started;
        logic [47:0] word_offset;
    } t_out_item;

endpackage

// ===== rtl/core/pbve_vb_enc.sv =====
// Variable-byte encoder for one 32-bit value, low byte first.
// Depends on pbve_pkg.
module pbve_vb_enc (
    input  logic [31:0] i_value,
    output logic [39:0] o_code,
    output logic [2:0]  o_len
);

    logic [34:0] ext;

    assign ext = {3'b000, i_value};

    always_comb begin
        priority if (i_value[31:28] != 4'd0) begin
            o_len = 3'd5;
        end else if (i_value[27:21] != 7'd0) begin
            o_len = 3'd4;
        end else if (i_value[20:14] != 7'd0) begin
            o_len = 3'd3;
        end else if (i_value[13:7] != 7'd0) begin
            o_len = 3'd2;
        end else begin
            o_len = 3'd1;
        end
    end

    always_comb begin
        for (int i = 0; i < pbve_pkg::VB_MAX_BYTES; i++) begin
            o_code[8*i +: 8] = {(3'(i + 1) < o_len) ? pbve_pkg::VB_CONT : 1'b0,
                                ext[7*i +: 7]};
        end
    end

endmodule

// ===== rtl/core/posting_block_varbyte_encoder_unit.sv =====
// Top level of the posting block varbyte encoder: input register, encode
// and block bookkeeping, result register. Depends on pbve_pkg, pbve_vb_enc.
//
// Use: postings (word_id, doc_id, freq) or a flush marker enter on the
// input channel (i_in_valid / o_in_ready / i_in_item); one result item per
// input item leaves on the output channel (o_out_valid / i_out_ready /
// o_out_item), in order.
// Path: an accepted item is held in the input register; its result is
// loaded into the result register once that is empty or being taken.
// Throughput: one item per cycle while i_out_ready is high. The block
// state (current word, previous doc, block count, byte totals, byte
// offset) updates in the same cycle the item is encoded, so consecutive
// items need no bubbles.
// Stall: when the receiver holds i_out_ready low the result stays in place,
// the input register keeps its item and o_in_ready drops once both are full.
// Reset: synchronous, active low; both registers empty, current word 1,
// all other state zero. No clearing pass.
module posting_block_varbyte_encoder_unit #(
    parameter int unsigned BLOCK_LEN = pbve_pkg::BLOCK_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pbve_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pbve_pkg::t_out_item  o_out_item
);

    localparam int unsigned CntW = $clog2(BLOCK_LEN + 1);

    logic                r_in_valid;
    pbve_pkg::t_in_item  r_in;
    logic                r_out_valid;
    pbve_pkg::t_out_item r_out;

    logic [31:0]     r_cur_word, n_cur_word;
    logic [31:0]     r_prev_doc, n_prev_doc;
    logic [CntW-1:0] r_count,    n_count;
    logic [9:0]      r_gap_sum,  n_gap_sum;
    logic [9:0]      r_freq_sum, n_freq_sum;
    logic [47:0]     r_offset,   n_offset;
    pbve_pkg::t_out_item n_out;

    logic        advance;
    logic        word_change;
    logic        do_close;
    logic        block_empty;
    logic [47:0] offset_adv;
    logic [31:0] gap;
    logic [39:0] gap_code;
    logic [39:0] freq_code;
    logic [2:0]  gap_len;
    logic [2:0]  freq_len;
    logic [10:0] gap_acc;
    logic [10:0] freq_acc;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign word_change = !r_in.flush && (r_in.word_id != r_cur_word);
    assign block_empty = (r_count == '0);
    assign do_close    = !block_empty && (r_in.flush || word_change ||
                                          (r_count >= CntW'(BLOCK_LEN)));
    assign offset_adv  = r_offset + pbve_pkg::HEADER_BYTES
                       + {38'd0, r_gap_sum} + {38'd0, r_freq_sum};
    assign gap = (block_empty || do_close) ? r_in.doc_id
                                           : (r_in.doc_id - r_prev_doc);

    pbve_vb_enc u_gap_enc (
        .i_value (gap),
        .o_code  (gap_code),
        .o_len   (gap_len)
    );

    pbve_vb_enc u_freq_enc (
        .i_value (r_in.freq),
        .o_code  (freq_code),
        .o_len   (freq_len)
    );

    always_comb begin
        gap_acc  = (do_close ? 11'd0 : {1'b0, r_gap_sum})  + {8'd0, gap_len};
        freq_acc = (do_close ? 11'd0 : {1'b0, r_freq_sum}) + {8'd0, freq_len};

        n_out = '0;
        if (do_close) begin
            n_out.block_closed      = 1'b1;
            n_out.closed_last_doc   = r_prev_doc;
            n_out.closed_gap_bytes  = r_gap_sum;
            n_out.closed_freq_bytes = r_freq_sum;
        end
        if (word_change) begin
            n_out.word_started = 1'b1;
            n_out.word_offset  = do_close ? offset_adv : r_offset;
        end
        if (!r_in.flush) begin
            n_out.posting_valid = 1'b1;
            n_out.gap_code      = gap_code;
            n_out.gap_len       = gap_len;
            n_out.freq_code     = freq_code;
            n_out.freq_len      = freq_len;
        end

        n_cur_word = r_cur_word;
        n_prev_doc = r_prev_doc;
        n_count    = r_count;
        n_gap_sum  = r_gap_sum;
        n_freq_sum = r_freq_sum;
        n_offset   = do_close ? offset_adv : r_offset;
        if (r_in.flush) begin
            if (do_close) begin
                n_count    = '0;
                n_gap_sum  = '0;
                n_freq_sum = '0;
            end
        end else begin
            n_cur_word = r_in.word_id;
            n_prev_doc = r_in.doc_id;
            n_count    = (do_close ? '0 : r_count) + CntW'(1);
            n_gap_sum  = gap_acc[10]  ? pbve_pkg::SUM_MAX : gap_acc[9:0];
            n_freq_sum = freq_acc[10] ? pbve_pkg::SUM_MAX : freq_acc[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur_word  <= 32'd1;
            r_prev_doc  <= '0;
            r_count     <= '0;
            r_gap_sum   <= '0;
            r_freq_sum  <= '0;
            r_offset    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_cur_word  <= n_cur_word;
                r_prev_doc  <= n_prev_doc;
                r_count     <= n_count;
                r_gap_sum   <= n_gap_sum;
                r_freq_sum  <= n_freq_sum;
                r_offset    <= n_offset;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/core/pbve_checker.sv =====
// Port-level checker for the posting block varbyte encoder, bound to the
// top level. Depends on pbve_pkg.
module pbve_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input pbve_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.posting_valid) |->
            (o_out_item.gap_len != 3'd0 && o_out_item.gap_len <= 3'd5 &&
             o_out_item.freq_len != 3'd0 && o_out_item.freq_len <= 3'd5))
        else $error("code length out of range");

    a_flush_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.posting_valid) |->
            (o_out_item.gap_len == 3'd0 && o_out_item.freq_len == 3'd0 &&
             !o_out_item.word_started))
        else $error("flush item carries posting fields");

    a_closed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.block_closed) |->
            (o_out_item.closed_gap_bytes == 10'd0 &&
             o_out_item.closed_freq_bytes == 10'd0))
        else $error("header fields set without a closed block");

endmodule

bind posting_block_varbyte_encoder_unit pbve_checker u_pbve_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
